[rtl/kte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kte_pkg
// Types and constants shared by the keyed table with expiry.
// ----------------------------------------------------------------------------
package kte_pkg;

    localparam int MODE_W   = 2;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int NOW_W    = 48;
    localparam int EXP_W    = 49;
    localparam int AGE_W    = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // Table word layout: valid, key, value, expiry (most to least significant).
    localparam int WORD_W    = 1 + KEY_W + VAL_W + EXP_W;
    localparam int EXP_LSB   = 0;
    localparam int VAL_LSB   = EXP_LSB + EXP_W;
    localparam int KEY_LSB   = VAL_LSB + VAL_W;
    localparam int VALID_BIT = KEY_LSB + KEY_W;

    localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STS_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_HIT      = 3'd2;
    localparam logic [STATUS_W-1:0] STS_MISS     = 3'd3;
    localparam logic [STATUS_W-1:0] STS_EXPIRED  = 3'd4;
    localparam logic [STATUS_W-1:0] STS_REMOVED  = 3'd5;
    localparam logic [STATUS_W-1:0] STS_ABSENT   = 3'd6;
    localparam logic [STATUS_W-1:0] STS_FULL     = 3'd7;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic scan_rd;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic addr_last;
    } t_dp_sts;

endpackage

[rtl/kte_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kte_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/kte_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kte_ctrl
// Sequencer: clearing pass after reset, then scan, decide and write back per
// request.
// ----------------------------------------------------------------------------
module kte_ctrl import kte_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.addr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            S_CLEAR: o_cmd.clear_wr = 1'b1;
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_SCAN:  o_cmd.scan_rd = 1'b1;
            S_DRAIN: o_cmd = '0;
            S_EXEC:  o_cmd.exec = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

[rtl/kte_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kte_dp
// Datapath: request registers, table RAM, scan compare, result registers.
// ----------------------------------------------------------------------------
module kte_dp import kte_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_sts                    o_sts,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic [KEY_W-1:0]           i_key,
    input  logic signed [VAL_W-1:0]    i_value,
    input  logic [NOW_W-1:0]           i_now,
    input  logic                       i_cfg_valid,
    input  logic [AGE_W-1:0]           i_cfg_data,
    output logic                       o_done,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [VAL_W-1:0]    o_read_value,
    output logic [COUNT_W-1:0]         o_entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Request and configuration
    logic [AGE_W-1:0]  r_age;
    logic [MODE_W-1:0] r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_value;
    logic [NOW_W-1:0]  r_now;

    // Scan
    logic [AW-1:0]     r_addr;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_idx;
    logic              r_hit;
    logic [AW-1:0]     r_hit_slot;
    logic [VAL_W-1:0]  r_hit_val;
    logic [EXP_W-1:0]  r_hit_exp;
    logic              r_free;
    logic [AW-1:0]     r_free_slot;

    // Result
    logic [CW-1:0]     r_count;
    logic              r_done;
    logic [STATUS_W-1:0] r_status;
    logic [VAL_W-1:0]  r_rdata;

    logic [WORD_W-1:0] rd_word;
    logic              rd_valid;
    logic              rd_match;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [EXP_W-1:0]  new_exp;
    logic              ex_we;
    logic [AW-1:0]     ex_addr;
    logic              ex_inc;
    logic              ex_dec;
    logic [STATUS_W-1:0] ex_status;
    logic [VAL_W-1:0]  ex_rdata;
    logic              addr_last;

    assign addr_last       = (r_addr == AW'(CAPACITY - 1));
    assign o_sts.addr_last = addr_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= '0;
        end else if (i_cfg_valid) begin
            r_age <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_key   <= i_key;
            r_value <= i_value;
            r_now   <= i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.clear_wr || i_cmd.scan_rd) begin
            r_addr <= addr_last ? '0 : r_addr + AW'(1);
        end
    end

    kte_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.scan_rd),
        .i_raddr (r_addr),
        .o_rdata (rd_word)
    );

    assign rd_valid = rd_word[VALID_BIT];
    assign rd_match = rd_valid && (rd_word[KEY_LSB +: KEY_W] == r_key);

    // The first matching slot and the first free slot are kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else if (r_rd_vld) begin
                if (rd_match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (!rd_valid && !r_free) begin
                    r_free <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (r_rd_vld && rd_match && !r_hit) begin
            r_hit_slot <= r_rd_idx;
            r_hit_val  <= rd_word[VAL_LSB +: VAL_W];
            r_hit_exp  <= rd_word[EXP_LSB +: EXP_W];
        end
        if (r_rd_vld && !rd_valid && !r_free) begin
            r_free_slot <= r_rd_idx;
        end
    end

    assign new_exp = (r_age == '0) ? '0
                   : ({1'b0, r_now} + EXP_W'(r_age));

    always_comb begin
        ex_we     = 1'b0;
        ex_addr   = r_hit_slot;
        ex_inc    = 1'b0;
        ex_dec    = 1'b0;
        ex_status = STS_ABSENT;
        ex_rdata  = '0;
        case (r_mode)
            MODE_SET: begin
                if (r_hit) begin
                    ex_we     = 1'b1;
                    ex_status = STS_UPDATED;
                end else if (r_free) begin
                    ex_we     = 1'b1;
                    ex_addr   = r_free_slot;
                    ex_inc    = 1'b1;
                    ex_status = STS_INSERTED;
                end else begin
                    ex_status = STS_FULL;
                end
            end
            MODE_GET: begin
                if (!r_hit) begin
                    ex_status = STS_MISS;
                end else if ((r_hit_exp != '0) && (r_hit_exp < {1'b0, r_now})) begin
                    ex_status = STS_EXPIRED;
                end else begin
                    ex_status = STS_HIT;
                    ex_rdata  = r_hit_val;
                end
            end
            MODE_REMOVE: begin
                if (r_hit) begin
                    ex_we     = 1'b1;
                    ex_dec    = 1'b1;
                    ex_status = STS_REMOVED;
                end
            end
            default: ex_status = STS_ABSENT;
        endcase
    end

    // A remove writes the word back with the valid bit low.
    always_comb begin
        if (i_cmd.clear_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = i_cmd.exec && ex_we;
            ram_waddr = ex_addr;
            ram_wdata = {(r_mode != MODE_REMOVE), r_key, r_value, new_exp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (i_cmd.exec && ex_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.exec && ex_dec && (r_count != '0)) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= ex_status;
            r_rdata  <= ex_rdata;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_read_value  = r_rdata;
    assign o_entry_count = COUNT_W'(r_count);

endmodule

[rtl/keyed_table_with_expiry_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_table_with_expiry_unit
// Integer-keyed table of CAPACITY entries with value and expiry time.
// ----------------------------------------------------------------------------
// Usage:
//   A request (i_mode, i_key, i_value, i_now) is taken at a clock edge where
//   start is high and busy is low. Set inserts or updates a key, get looks it
//   up and checks its expiry against i_now, remove frees the entry.
//   Exactly one result per request appears on o_status, o_read_value and
//   o_entry_count for one cycle with o_done high; the receiver cannot stall.
//   Sequence: the table lives in one RAM with a single read port, and each
//   request scans every entry through it, then a drain step takes the last
//   read and an exec step does the write-back; o_done is registered from the
//   exec step. busy is low while o_done is high, so the next request can be
//   taken at the edge that ends it; a request is not taken while an earlier
//   one is still scanning, draining or writing back.
//   max_age is written through i_cfg_valid / i_cfg_data; o_cfg_ready is
//   always high, and writes are meant only while no request is in flight.
//   Reset: after i_rst_n is released, a clearing pass writes every entry
//   invalid, one per cycle, with busy high. max_age resets to zero and the
//   entry count to zero.
// ----------------------------------------------------------------------------
module keyed_table_with_expiry_unit import kte_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic [KEY_W-1:0]        i_key,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [NOW_W-1:0]        i_now,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [AGE_W-1:0]        i_cfg_data,
    output logic                    o_done,
    output logic [STATUS_W-1:0]     o_status,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic [COUNT_W-1:0]      o_entry_count
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    kte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    kte_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_now         (i_now),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

    // A result is shown only once the sequencer is back in idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted request did not make the unit busy");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear_wr |-> (!cmd.scan_rd && !cmd.exec && busy))
        else $error("clearing pass overlaps a request");

endmodule

[sim/tb_keyed_table_with_expiry_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_table_with_expiry_unit
// Self-checking bench for the keyed table with expiry. A tracker class keeps
// its own copy of the table and the max_age register. It works out the reply
// to every request at the moment the request is taken, and compares each
// o_done transfer against the oldest reply still awaited. Stimulus is a short
// list of corner cases followed by fill, mixed and drain sequences. Each
// sequence group runs under its own max_age and its own rate of sender pauses.
// ----------------------------------------------------------------------------

localparam int TABLE_SLOTS = 64;

typedef struct {
    logic [kte_pkg::STATUS_W-1:0] status;
    logic [kte_pkg::VAL_W-1:0]    read_value;
    logic [kte_pkg::COUNT_W-1:0]  entry_count;
} t_table_reply;

class expiry_table_tracker;
    logic [TABLE_SLOTS-1:0]                         slot_used;
    logic [TABLE_SLOTS-1:0][kte_pkg::KEY_W-1:0]     slot_key;
    logic [TABLE_SLOTS-1:0][kte_pkg::VAL_W-1:0]     slot_value;
    logic [TABLE_SLOTS-1:0][kte_pkg::EXP_W-1:0]     slot_expiry;
    logic [kte_pkg::COUNT_W-1:0]                    stored;
    logic [kte_pkg::AGE_W-1:0]                      max_age;
    t_table_reply                                   awaited[$];
    int                                             errors;

    function new();
        slot_used   = '0;
        slot_key    = '0;
        slot_value  = '0;
        slot_expiry = '0;
        stored      = '0;
        max_age     = '0;
        errors      = 0;
    endfunction

    // Updates the table copy for one taken request and queues its reply.
    function void apply_request(input logic [kte_pkg::MODE_W-1:0] mode,
                                input logic [kte_pkg::KEY_W-1:0]  key,
                                input logic [kte_pkg::VAL_W-1:0]  value,
                                input logic [kte_pkg::NOW_W-1:0]  now);
        int                        hit_slot;
        int                        free_slot;
        logic [kte_pkg::EXP_W-1:0] expiry;
        t_table_reply              reply;
        hit_slot  = -1;
        free_slot = -1;
        // The sum is formed at the full expiry width, so it never wraps.
        expiry = (max_age == '0) ? '0 : {1'b0, now} + kte_pkg::EXP_W'(max_age);
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_used[i] && slot_key[i] == key && hit_slot < 0)
                hit_slot = i;
            if (!slot_used[i] && free_slot < 0)
                free_slot = i;
        end
        reply.status     = kte_pkg::STS_ABSENT;
        reply.read_value = '0;
        case (mode)
            kte_pkg::MODE_SET: begin
                if (hit_slot >= 0) begin
                    slot_value[hit_slot]  = value;
                    slot_expiry[hit_slot] = expiry;
                    reply.status          = kte_pkg::STS_UPDATED;
                end else if (free_slot < 0) begin
                    reply.status = kte_pkg::STS_FULL;
                end else begin
                    slot_used[free_slot]   = 1'b1;
                    slot_key[free_slot]    = key;
                    slot_value[free_slot]  = value;
                    slot_expiry[free_slot] = expiry;
                    stored                 = stored + 1'b1;
                    reply.status           = kte_pkg::STS_INSERTED;
                end
            end
            kte_pkg::MODE_GET: begin
                if (hit_slot < 0) begin
                    reply.status = kte_pkg::STS_MISS;
                end else if (slot_expiry[hit_slot] != '0 &&
                             slot_expiry[hit_slot] < {1'b0, now}) begin
                    reply.status = kte_pkg::STS_EXPIRED;
                end else begin
                    reply.status     = kte_pkg::STS_HIT;
                    reply.read_value = slot_value[hit_slot];
                end
            end
            kte_pkg::MODE_REMOVE: begin
                if (hit_slot >= 0) begin
                    slot_used[hit_slot] = 1'b0;
                    stored              = stored - 1'b1;
                    reply.status        = kte_pkg::STS_REMOVED;
                end
            end
            default: ;
        endcase
        reply.entry_count = stored;
        awaited.push_back(reply);
    endfunction

    task report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(input logic [kte_pkg::STATUS_W-1:0] status,
                      input logic [kte_pkg::VAL_W-1:0]    read_value,
                      input logic [kte_pkg::COUNT_W-1:0]  entry_count);
        t_table_reply want;
        if (awaited.size() == 0) begin
            report_mismatch("result transfer with no request outstanding");
        end else begin
            want = awaited.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status got %0d, expected %0d",
                                          status, want.status));
            if (read_value !== want.read_value)
                report_mismatch($sformatf("read_value got %h, expected %h",
                                          read_value, want.read_value));
            if (entry_count !== want.entry_count)
                report_mismatch($sformatf("entry_count got %0d, expected %0d",
                                          entry_count, want.entry_count));
        end
    endtask

    task flush_leftovers();
        if (awaited.size() != 0)
            report_mismatch($sformatf("%0d requests never produced a result",
                                      awaited.size()));
    endtask
endclass

module tb_keyed_table_with_expiry_unit;
    import kte_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 80;
    localparam int POOL_SIZE    = 72;
    localparam int MIX_ITEMS    = 135;
    localparam int PHASES       = 5;

    // Mode 3 has no meaning; the block must report it as absent.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [NOW_W-1:0]  NOW_MAX     = '1;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic [MODE_W-1:0]   i_mode      = MODE_SET;
    logic [KEY_W-1:0]    i_key       = '0;
    logic [VAL_W-1:0]    i_value     = '0;
    logic [NOW_W-1:0]    i_now       = '0;
    logic                i_cfg_valid = 1'b0;
    logic [AGE_W-1:0]    i_cfg_data  = '0;
    logic                busy;
    logic                o_cfg_ready;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [VAL_W-1:0]    o_read_value;
    logic [COUNT_W-1:0]  o_entry_count;

    expiry_table_tracker tracker;
    logic [KEY_W-1:0]    key_pool [POOL_SIZE];
    logic [NOW_W-1:0]    clock_ms = '0;
    int                  stall_cycles = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    keyed_table_with_expiry_unit #(
        .CAPACITY(TABLE_SLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_now        (i_now),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_entry_count(o_entry_count)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            tracker.check_result(o_status, o_read_value, o_entry_count);
    end

    // Any transfer on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [KEY_W-1:0]  key,
                                input logic [VAL_W-1:0]  value,
                                input logic [NOW_W-1:0]  now);
        start   <= 1'b1;
        i_mode  <= mode;
        i_key   <= key;
        i_value <= value;
        i_now   <= now;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker.apply_request(mode, key, value, now);
    endtask

    // The idle cycles are placed where the block could take a request, so
    // that they are seen by the block and not hidden behind busy.
    task automatic sender_pause(input int pct);
        if ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while (busy) @(posedge i_clk);
            repeat ($urandom_range(0, 3)) @(posedge i_clk);
        end
    endtask

    // max_age changes only while no request is in flight.
    task automatic write_max_age(input logic [AGE_W-1:0] age);
        if (start)
            start <= 1'b0;
        do @(posedge i_clk); while (tracker.awaited.size() != 0 || busy);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= age;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.max_age = age;
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly a slowly advancing clock, so that entries age out between
    // requests; now and then a random or near-maximum time.
    function automatic logic [NOW_W-1:0] next_time();
        int pick;
        pick     = $urandom_range(0, 99);
        clock_ms = clock_ms + NOW_W'($urandom_range(0, 20));
        if (pick < 8)
            return {16'($urandom), 32'($urandom)};
        if (pick < 14)
            return NOW_MAX - NOW_W'($urandom_range(0, 64));
        return clock_ms;
    endfunction

    task automatic send_mixed_request();
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            mode = MODE_SET;
        else if (pick < 75)
            mode = MODE_GET;
        else if (pick < 95)
            mode = MODE_REMOVE;
        else
            mode = MODE_UNUSED;
        key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        pick = $urandom_range(0, 99);
        // Fresh keys are kept rare on sets, since nothing ever removes them.
        if ((mode != MODE_SET && pick < 15) || pick < 2)
            key = $urandom;
        send_request(mode, key, $urandom, next_time());
    endtask

    task automatic run_phase(input logic [AGE_W-1:0] age, input int pct);
        int offset;
        offset = $urandom_range(0, POOL_SIZE - 1);
        write_max_age(age);
        // The pool is larger than the table, so each fill runs into full.
        for (int i = 0; i < POOL_SIZE; i++) begin
            send_request(MODE_SET, key_pool[(i + offset) % POOL_SIZE], $urandom, next_time());
            sender_pause(pct);
        end
        repeat (MIX_ITEMS) begin
            send_mixed_request();
            sender_pause(pct);
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            send_request(MODE_REMOVE, key_pool[i], $urandom, next_time());
            sender_pause(pct);
        end
    endtask

    initial begin
        logic [AGE_W-1:0] phase_age [PHASES];
        int               phase_pct [PHASES];
        tracker     = new();
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 32'd1;
        key_pool[3] = 32'd2;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        phase_age = '{32'd0, 32'd40, 32'd1, 32'($urandom_range(20, 400)), 32'hFFFF_FFFF};
        phase_pct = '{0, 50, 30, 0, 50};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Entries never expire while max_age is zero.
        send_request(MODE_GET,    32'd0,        32'h1234_5678, '0);
        send_request(MODE_REMOVE, 32'd0,        32'h0,         '0);
        send_request(MODE_UNUSED, 32'd0,        32'hFFFF_FFFF, NOW_MAX);
        send_request(MODE_SET,    32'd0,        32'h8000_0000, '0);
        send_request(MODE_SET,    32'hFFFF_FFFF, 32'h7FFF_FFFF, NOW_MAX);
        send_request(MODE_GET,    32'hFFFF_FFFF, 32'h0,         NOW_MAX);
        send_request(MODE_SET,    32'd0,        32'd1,         48'd5);
        send_request(MODE_GET,    32'd0,        32'hDEAD_BEEF, 48'd6);
        send_request(MODE_REMOVE, 32'd0,        32'h0,         48'd7);
        send_request(MODE_GET,    32'd0,        32'h0,         48'd8);

        // Largest lifetime on the largest time: the expiry needs its top bit.
        write_max_age(32'hFFFF_FFFF);
        send_request(MODE_SET,    32'd1,        32'hFFFF_FFFF, NOW_MAX);
        send_request(MODE_GET,    32'd1,        32'h0,         NOW_MAX);
        send_request(MODE_SET,    32'hFFFF_FFFF, 32'h5A5A_A5A5, '0);
        send_request(MODE_GET,    32'hFFFF_FFFF, 32'h0,         48'h1_0000_0000);

        // An entry is still live on its expiry time and expired one later.
        write_max_age(32'd10);
        send_request(MODE_SET,    32'd2,        32'd42,        48'd100);
        send_request(MODE_GET,    32'd2,        32'h0,         48'd110);
        send_request(MODE_GET,    32'd2,        32'h0,         48'd111);
        send_request(MODE_REMOVE, 32'd2,        32'h0,         48'd112);
        send_request(MODE_REMOVE, 32'd1,        32'h0,         48'd113);
        send_request(MODE_UNUSED, 32'hFFFF_FFFF, 32'h0,         48'd114);
        send_request(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0,         48'd115);

        for (int p = 0; p < PHASES; p++)
            run_phase(phase_age[p], phase_pct[p]);

        if (start)
            start <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        tracker.flush_leftovers();
        if (tracker.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
